FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, removed when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property holds at every clock edge outside reset
`define ASSERT_PROP(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);
// condition never holds at a clock edge outside reset
`define ASSERT_NEVER(lbl, ck, rstn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, ck, rstn, prop, msg)
`define ASSERT_NEVER(lbl, ck, rstn, cond, msg)
`endif
`endif

FILE: rtl/ncsc_pkg.sv
// ----------------------------------------------------------------------------
// ncsc_pkg
// types and constants of the nicd charge stage controller
// ----------------------------------------------------------------------------
package ncsc_pkg;

    // charge stages
    typedef enum logic [2:0] {
        STG_CELL    = 3'd0,
        STG_TYPE    = 3'd1,
        STG_PACK    = 3'd2,
        STG_PRE     = 3'd3,
        STG_FAST    = 3'd4,
        STG_TRICKLE = 3'd5,
        STG_STOP    = 3'd6,
        STG_ERR     = 3'd7
    } stage_t;

    // cell chemistry codes
    localparam logic [1:0] CHEM_UNKNOWN = 2'd0;
    localparam logic [1:0] CHEM_SINGLE  = 2'd1;
    localparam logic [1:0] CHEM_ARRAY   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_PRE_LO      = 3'd0;
    localparam logic [2:0] CFG_PRE_HI      = 3'd1;
    localparam logic [2:0] CFG_FAST_LO     = 3'd2;
    localparam logic [2:0] CFG_FAST_HI     = 3'd3;
    localparam logic [2:0] CFG_PRE_DWELL   = 3'd4;
    localparam logic [2:0] CFG_TRK_CHECKS  = 3'd5;
    localparam logic [2:0] CFG_TRK_PERIOD  = 3'd6;
    localparam logic [2:0] CFG_MAX_DUTY    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // per-cell thresholds in mV
    localparam logic [10:0] CELL_MV_1300 = 11'd1300;
    localparam logic [10:0] CELL_MV_1380 = 11'd1380;
    localparam logic [10:0] CELL_MV_1395 = 11'd1395;
    localparam logic [10:0] CELL_MV_1400 = 11'd1400;
    localparam logic [10:0] CELL_MV_1405 = 11'd1405;
    localparam logic [10:0] CELL_MV_1420 = 11'd1420;
    localparam logic [10:0] CELL_MV_1500 = 11'd1500;
    localparam logic [10:0] CELL_MV_1580 = 11'd1580;

    // fixed detection thresholds in mV
    localparam logic [13:0] DET_CELL_MV   = 14'd500;
    localparam logic [13:0] DET_SINGLE_MV = 14'd1500;
    localparam logic [13:0] DET_PACK2_MV  = 14'd2000;
    localparam logic [13:0] DET_PACK4_MV  = 14'd4000;
    localparam logic [13:0] DET_PACK7_MV  = 14'd7000;

    // fixed current windows for packs of seven
    localparam logic [11:0] P7_PRE_LO_MA  = 12'd50;
    localparam logic [11:0] P7_PRE_HI_MA  = 12'd370;
    localparam logic [11:0] P7_FAST_LO_MA = 12'd120;
    localparam logic [11:0] P7_FAST_HI_MA = 12'd400;

    localparam logic [4:0] DUTY_LIMIT = 5'd20;
    localparam logic [5:0] DWELL_MAX  = 6'd63;
    localparam logic [4:0] TICKS_MAX  = 5'd31;

    // input word
    typedef struct packed {
        logic [13:0] voltage_mv;
        logic [11:0] current_ma;
        logic [13:0] voltage_off_mv;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [2:0] stage;
        logic [4:0] duty;
        logic       drive_on;
        logic [2:0] pack_cells;
        logic [1:0] cell_chem;
    } out_word_t;

    // configuration register values
    typedef struct packed {
        logic [11:0] pre_current_low_ma;
        logic [11:0] pre_current_high_ma;
        logic [11:0] fast_current_low_ma;
        logic [11:0] fast_current_high_ma;
        logic [5:0]  pre_dwell_limit;
        logic [4:0]  trickle_check_limit;
        logic [4:0]  trickle_period_ticks;
        logic [4:0]  max_duty;
    } cfg_t;

    // controller state
    typedef struct packed {
        stage_t     stage;
        logic [4:0] duty;
        logic       drive;
        logic [2:0] pack;
        logic [1:0] chem;
        logic [5:0] dwell;
        logic [4:0] ticks;
    } ctl_state_t;

    // pack threshold: per-cell millivolts times cell count
    function automatic logic [13:0] pack_mv(input logic [2:0] cells,
                                            input logic [10:0] per_cell);
        return 14'(per_cell) * 14'(cells);
    endfunction

endpackage

FILE: rtl/ncsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ncsc_cfg_regs
// configuration register file written through a plain write port
// ----------------------------------------------------------------------------
module ncsc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ncsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ncsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output ncsc_pkg::cfg_t                cfg
);
    import ncsc_pkg::*;

    cfg_t cfg_reg;

    // register writes, each field keeps its low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_current_low_ma   <= 12'd350;
            cfg_reg.pre_current_high_ma  <= 12'd450;
            cfg_reg.fast_current_low_ma  <= 12'd700;
            cfg_reg.fast_current_high_ma <= 12'd800;
            cfg_reg.pre_dwell_limit      <= 6'd40;
            cfg_reg.trickle_check_limit  <= 5'd15;
            cfg_reg.trickle_period_ticks <= 5'd12;
            cfg_reg.max_duty             <= 5'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRE_LO:     cfg_reg.pre_current_low_ma   <= cfg_data;
                CFG_PRE_HI:     cfg_reg.pre_current_high_ma  <= cfg_data;
                CFG_FAST_LO:    cfg_reg.fast_current_low_ma  <= cfg_data;
                CFG_FAST_HI:    cfg_reg.fast_current_high_ma <= cfg_data;
                CFG_PRE_DWELL:  cfg_reg.pre_dwell_limit      <= cfg_data[5:0];
                CFG_TRK_CHECKS: cfg_reg.trickle_check_limit  <= cfg_data[4:0];
                CFG_TRK_PERIOD: cfg_reg.trickle_period_ticks <= cfg_data[4:0];
                CFG_MAX_DUTY:   cfg_reg.max_duty             <= cfg_data[4:0];
                default:        cfg_reg.max_duty             <= cfg_reg.max_duty;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ncsc_step.sv
// ----------------------------------------------------------------------------
// ncsc_step
// next controller state for one sample word
// ----------------------------------------------------------------------------
module ncsc_step (
    input  ncsc_pkg::ctl_state_t cur,
    input  ncsc_pkg::in_word_t   word,
    input  ncsc_pkg::cfg_t       cfg,
    output ncsc_pkg::ctl_state_t nxt
);
    import ncsc_pkg::*;

    logic [13:0] v;
    logic [11:0] cur_ma;
    logic [13:0] voff;
    logic [2:0]  p;
    logic [2:0]  p_live;
    logic        v_zero;
    logic [4:0]  max_d;
    logic [4:0]  period;
    logic [5:0]  dwell_inc;
    logic [4:0]  ticks_inc;
    logic [11:0] pre_lo;
    logic [11:0] pre_hi;
    logic [11:0] fast_lo;
    logic [11:0] fast_hi;
    logic [4:0]  duty_pre;
    logic [4:0]  duty_fast;

    // one duty step toward the current window
    function automatic logic [4:0] regulate(input logic [4:0] duty,
                                            input logic [11:0] ma,
                                            input logic [11:0] lo,
                                            input logic [11:0] hi,
                                            input logic [4:0] mx);
        logic [5:0] up;
        logic [4:0] d;
        up = {1'b0, duty} + 6'd1;
        d  = duty;
        if (ma < lo)
            d = (up > {1'b0, mx}) ? mx : up[4:0];
        if (ma > hi)
            d = (d <= 5'd1) ? 5'd1 : d - 5'd1;
        return d;
    endfunction

    // operand prep
    always_comb
    begin
        v         = word.voltage_mv;
        cur_ma    = word.current_ma;
        voff      = word.voltage_off_mv;
        p         = cur.pack;
        v_zero    = (v == 14'd0);
        p_live    = v_zero ? 3'd0 : p;
        max_d     = (cfg.max_duty == 5'd0) ? 5'd1 :
                    ((cfg.max_duty > DUTY_LIMIT) ? DUTY_LIMIT : cfg.max_duty);
        period    = (cfg.trickle_period_ticks == 5'd0) ? 5'd1 : cfg.trickle_period_ticks;
        dwell_inc = (cur.dwell < DWELL_MAX) ? cur.dwell + 6'd1 : cur.dwell;
        ticks_inc = (cur.ticks < TICKS_MAX) ? cur.ticks + 5'd1 : cur.ticks;
        pre_lo    = (p == 3'd7) ? P7_PRE_LO_MA  : cfg.pre_current_low_ma;
        pre_hi    = (p == 3'd7) ? P7_PRE_HI_MA  : cfg.pre_current_high_ma;
        fast_lo   = (p == 3'd7) ? P7_FAST_LO_MA : cfg.fast_current_low_ma;
        fast_hi   = (p == 3'd7) ? P7_FAST_HI_MA : cfg.fast_current_high_ma;
        duty_pre  = regulate(cur.duty, cur_ma, pre_lo, pre_hi, max_d);
        duty_fast = regulate(cur.duty, cur_ma, fast_lo, fast_hi, max_d);
    end

    // stage transitions
    always_comb
    begin
        nxt = cur;
        case (cur.stage)
            STG_CELL:
            begin
                if (v < DET_CELL_MV)
                begin
                    nxt.duty  = 5'd1;
                    nxt.drive = 1'b1;
                end
                else
                begin
                    nxt.stage = STG_TYPE;
                    nxt.drive = 1'b0;
                end
            end
            STG_TYPE:
            begin
                nxt.duty  = 5'd1;
                nxt.drive = 1'b1;
                if (v < DET_SINGLE_MV)
                begin
                    nxt.chem  = CHEM_SINGLE;
                    nxt.pack  = 3'd1;
                    nxt.stage = STG_PRE;
                    nxt.drive = 1'b0;
                end
                else if (v >= DET_PACK2_MV)
                begin
                    nxt.chem  = CHEM_ARRAY;
                    nxt.pack  = 3'd2;
                    nxt.stage = STG_PACK;
                    nxt.drive = 1'b0;
                end
            end
            STG_PACK:
            begin
                nxt.duty  = 5'd1;
                nxt.drive = 1'b1;
                if (v >= DET_PACK7_MV)
                begin
                    nxt.pack  = 3'd7;
                    nxt.stage = STG_PRE;
                    nxt.drive = 1'b0;
                end
                else if (v >= DET_PACK4_MV)
                begin
                    nxt.pack  = 3'd4;
                    nxt.stage = STG_PRE;
                    nxt.drive = 1'b0;
                end
                else if (v >= DET_PACK2_MV)
                begin
                    nxt.pack  = 3'd2;
                    nxt.stage = STG_PRE;
                    nxt.drive = 1'b0;
                end
                else
                begin
                    // pack too low, drive stays on until error stop runs
                    nxt.chem  = CHEM_UNKNOWN;
                    nxt.pack  = 3'd0;
                    nxt.stage = STG_ERR;
                end
            end
            STG_PRE:
            begin
                nxt.drive = 1'b1;
                if (v > pack_mv(p, CELL_MV_1300))
                begin
                    nxt.dwell = dwell_inc;
                    if (dwell_inc > cfg.pre_dwell_limit)
                    begin
                        nxt.stage = STG_FAST;
                        nxt.drive = 1'b0;
                        nxt.dwell = 6'd0;
                    end
                end
                if (v > pack_mv(p, CELL_MV_1500))
                begin
                    nxt.stage = STG_TRICKLE;
                    nxt.drive = 1'b0;
                end
                else
                begin
                    nxt.duty = duty_pre;
                    if (v_zero)
                    begin
                        nxt.chem  = CHEM_UNKNOWN;
                        nxt.pack  = 3'd0;
                        nxt.stage = STG_CELL;
                    end
                end
            end
            STG_FAST:
            begin
                nxt.drive = 1'b1;
                if (v < pack_mv(p, CELL_MV_1300))
                begin
                    nxt.stage = STG_PRE;
                    nxt.drive = 1'b0;
                end
                else if (v > pack_mv(p, CELL_MV_1580))
                begin
                    nxt.stage = STG_STOP;
                    nxt.drive = 1'b0;
                end
                else if (v > pack_mv(p, CELL_MV_1500))
                begin
                    nxt.stage = STG_TRICKLE;
                    nxt.drive = 1'b0;
                end
                else
                begin
                    nxt.duty = duty_fast;
                    if (v_zero)
                    begin
                        nxt.chem  = CHEM_UNKNOWN;
                        nxt.pack  = 3'd0;
                        nxt.stage = STG_CELL;
                    end
                end
            end
            STG_TRICKLE:
            begin
                nxt.duty  = 5'd1;
                nxt.drive = 1'b1;
                if (v > pack_mv(p, CELL_MV_1500))
                begin
                    nxt.stage = STG_STOP;
                    nxt.drive = 1'b0;
                    nxt.dwell = 6'd0;
                end
                else
                begin
                    if (v_zero)
                    begin
                        nxt.chem  = CHEM_UNKNOWN;
                        nxt.pack  = 3'd0;
                        nxt.stage = STG_CELL;
                    end
                    nxt.ticks = ticks_inc;
                    // rest check on the drive-off voltage
                    if (ticks_inc >= period)
                    begin
                        nxt.dwell = dwell_inc;
                        if (dwell_inc > {1'b0, cfg.trickle_check_limit})
                        begin
                            nxt.stage = STG_STOP;
                            nxt.drive = 1'b0;
                            nxt.dwell = 6'd0;
                        end
                        else
                        begin
                            nxt.drive = 1'b0;
                            nxt.ticks = 5'd0;
                            if (voff < pack_mv(p_live, CELL_MV_1380))
                            begin
                                nxt.stage = STG_FAST;
                                nxt.dwell = 6'd0;
                            end
                            else if (voff < pack_mv(p_live, CELL_MV_1400))
                            begin
                                nxt.stage = STG_PRE;
                                nxt.dwell = 6'd0;
                            end
                        end
                    end
                end
            end
            STG_STOP:
            begin
                nxt.drive = 1'b0;
                if (v_zero)
                begin
                    nxt.chem  = CHEM_UNKNOWN;
                    nxt.pack  = 3'd0;
                    nxt.stage = STG_CELL;
                end
                else if (v < pack_mv(p, CELL_MV_1395))
                begin
                    nxt.stage = STG_PRE;
                end
            end
            default:
            begin
                // error stop
                nxt.drive = 1'b0;
                if (v < pack_mv(p, CELL_MV_1420))
                begin
                    nxt.stage = STG_TRICKLE;
                end
                else if (v_zero)
                begin
                    nxt.chem  = CHEM_UNKNOWN;
                    nxt.pack  = 3'd0;
                    nxt.stage = STG_CELL;
                end
            end
        endcase
    end

endmodule

FILE: rtl/nicd_charge_stage_controller_unit.sv
// ----------------------------------------------------------------------------
// nicd_charge_stage_controller_unit
// nicd charge stage controller, one result word per sample word
// ----------------------------------------------------------------------------
// Each accepted sample word is registered, then compare logic against
// pack-scaled thresholds updates the stage, duty, drive, pack size, chemistry,
// dwell and trickle counters and loads the result register. A new word is taken
// every cycle unless in_stall is raised; throughput is set by the single step
// stage. The result register only holds up input when it is full and stalled.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// do so only while the block is idle, as the block itself does not enforce it.
module nicd_charge_stage_controller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ncsc_pkg::in_word_t              in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ncsc_pkg::out_word_t             out_word,
    input  logic                            cfg_we,
    input  logic [ncsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ncsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ncsc_pkg::*;

`include "assert_macros.svh"

    cfg_t       cfg;
    in_word_t   s1_word_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    ctl_state_t state_reg;
    ctl_state_t state_next;
    out_word_t  out_word_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       adv;
    logic       in_acc;

    ncsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ncsc_step u_step (
        .cur  (state_reg),
        .word (s1_word_reg),
        .cfg  (cfg),
        .nxt  (state_next)
    );

    // handshake between input register and result register
    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        adv            = s1_valid_reg && out_free;
        in_stall       = s1_valid_reg && !out_free;
        in_acc         = in_valid && !in_stall;
        s1_valid_next  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        out_valid_next = adv ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{stage: STG_CELL, duty: 5'd0, drive: 1'b0, pack: 3'd0,
                               chem: CHEM_UNKNOWN, dwell: 6'd0, ticks: 5'd0};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_word_reg <= in_word;
        if (adv)
        begin
            out_word_reg.stage      <= state_next.stage;
            out_word_reg.duty       <= state_next.duty;
            out_word_reg.drive_on   <= state_next.drive;
            out_word_reg.pack_cells <= state_next.pack;
            out_word_reg.cell_chem  <= state_next.chem;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // checks
    `ASSERT_PROP(a_pack_legal, clk, rst_n, state_reg.pack == 3'd0 || state_reg.pack == 3'd1 || state_reg.pack == 3'd2 || state_reg.pack == 3'd4 || state_reg.pack == 3'd7, "illegal pack size")
    `ASSERT_NEVER(a_duty_range, clk, rst_n, state_reg.duty > DUTY_LIMIT, "duty above limit")
    `ASSERT_PROP(a_chem_pack, clk, rst_n, (state_reg.chem == CHEM_UNKNOWN) == (state_reg.pack == 3'd0), "chemistry and pack disagree")
    `ASSERT_PROP(a_state_adv, clk, rst_n, !$stable(state_reg) |-> $past(adv), "state moved without a word")

endmodule
